@@ src/csp_pkg.sv @@
`timescale 1ns / 1ps
package csp_pkg;

  localparam int IN_TDATA_W  = 48;
  localparam int SCAN_W      = 45;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [15:0] HOLD_MS_RST    = 16'd1500;
  localparam logic [3:0]  PIECES_RST     = 4'd3;
  localparam logic [3:0]  BLUE_CODE_RST  = 4'd4;
  localparam logic [3:0]  GREEN_CODE_RST = 4'd1;
  localparam logic [3:0]  PIECE_MAX      = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_HOLD = 2'd0,
    CFG_PIECES     = 2'd1,
    CFG_BLUE_CODE  = 2'd2,
    CFG_GREEN_CODE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    B1_STOP       = 4'd0,
    B1_MOVE       = 4'd1,
    B1_WAIT_BOX   = 4'd2,
    B1_WAIT       = 4'd3,
    B1_PRESS_DOWN = 4'd4,
    B1_PRESS_HOLD = 4'd5,
    B1_PRESS_UP   = 4'd6,
    B1_PUSH       = 4'd7,
    B1_RETRACT    = 4'd8
  } b1_state_t;

  typedef enum logic [1:0] {
    B2_STOP  = 2'd0,
    B2_IN    = 2'd1,
    B2_OUT   = 2'd2,
    B2_COUNT = 2'd3
  } b2_state_t;

  typedef enum logic [1:0] {
    L_BLUE  = 2'd0,
    L_GREEN = 2'd1,
    L_NONE  = 2'd2
  } light_state_t;

  typedef struct packed {
    logic        start_button;
    logic        entry_sensor;
    logic [3:0]  color_value;
    logic        press_sensor;
    logic        pusher_out_sensor;
    logic        pusher_in_sensor;
    logic        box_sensor;
    logic        drop_sensor;
    logic        blue_switch;
    logic        green_switch;
    logic [31:0] time_now;
  } scan_t;

  typedef struct packed {
    logic [15:0] press_hold_ms;
    logic [3:0]  pieces_per_box;
    logic [3:0]  blue_code;
    logic [3:0]  green_code;
  } cfg_t;

  typedef struct packed {
    logic belt_run;
    logic busy;
    logic stopped;
    logic press_drive;
    logic pusher_drive;
  } b1_status_t;

  typedef struct packed {
    logic        belt_run;
    logic        busy;
    logic        stopped;
    logic [15:0] boxes_filled;
  } b2_status_t;

endpackage

@@ src/conveyor_sort_press_controller.sv @@
`timescale 1ns / 1ps
// Sort-and-press controller for a two-belt conveyor cell. Each input transfer is one scan of
// the plant and yields exactly one result transfer with the actuator and lamp bits and the
// finished-box count. The block takes one scan per clock cycle unless a held result stalls it: a scan
// sits in an input register until the three state machines step on it, and the result is
// shown from an output register from the next cycle on. The rate is set by the next-state
// update of the belt and light machines, which feed back into the following scan. When a
// result is held by out_tready low, one more scan is still taken into the input register.
// The configuration registers reset to a 1500 ms press hold, three pieces per box, blue
// code 4 and green code 1; cfg_ready is always high.
module conveyor_sort_press_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // start_button, entry_sensor, color_value[3:0], press_sensor, pusher_out_sensor,
  // pusher_in_sensor, box_sensor, drop_sensor, blue_switch, green_switch,
  // time_now[31:0], zero fill
  input  logic [csp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // belt1_run, station1_busy, idle_lamp, press_drive, pusher_drive, belt2_run,
  // station2_busy, green_lamp, blue_lamp, boxes_filled[15:0], zero fill
  output logic [csp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [csp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  csp_pkg::cfg_t                    cfg_r;
  logic                             in_valid_r;
  logic [csp_pkg::SCAN_W-1:0]       in_data_r;
  logic                             out_valid_r;
  logic [csp_pkg::OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                             step_en;
  logic                             in_xfer;
  csp_pkg::scan_t                   scan;
  csp_pkg::b2_state_t               b2_state;
  csp_pkg::light_state_t            light_state;
  csp_pkg::b1_status_t              b1_status;
  csp_pkg::b2_status_t              b2_status;
  logic                             green_lamp;
  logic                             blue_lamp;
  logic                             idle_lamp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.press_hold_ms  <= csp_pkg::HOLD_MS_RST;
      cfg_r.pieces_per_box <= csp_pkg::PIECES_RST;
      cfg_r.blue_code      <= csp_pkg::BLUE_CODE_RST;
      cfg_r.green_code     <= csp_pkg::GREEN_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (csp_pkg::cfg_idx_t'(cfg_index))
        csp_pkg::CFG_PRESS_HOLD: cfg_r.press_hold_ms  <= cfg_data;
        csp_pkg::CFG_PIECES:     cfg_r.pieces_per_box <= cfg_data[3:0];
        csp_pkg::CFG_BLUE_CODE:  cfg_r.blue_code      <= cfg_data[3:0];
        csp_pkg::CFG_GREEN_CODE: cfg_r.green_code     <= cfg_data[3:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) in_data_r <= in_tdata[csp_pkg::SCAN_W-1:0];
  end

  always_comb begin
    scan.start_button      = in_data_r[0];
    scan.entry_sensor      = in_data_r[1];
    scan.color_value       = in_data_r[5:2];
    scan.press_sensor      = in_data_r[6];
    scan.pusher_out_sensor = in_data_r[7];
    scan.pusher_in_sensor  = in_data_r[8];
    scan.box_sensor        = in_data_r[9];
    scan.drop_sensor       = in_data_r[10];
    scan.blue_switch       = in_data_r[11];
    scan.green_switch      = in_data_r[12];
    scan.time_now          = in_data_r[44:13];
  end

  csp_belt1 u_belt1 (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .scan        (scan),
    .cfg         (cfg_r),
    .b2_state    (b2_state),
    .light_state (light_state),
    .status      (b1_status)
  );

  csp_belt2 u_belt2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .scan    (scan),
    .cfg     (cfg_r),
    .state   (b2_state),
    .status  (b2_status)
  );

  csp_lights u_lights (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .scan       (scan),
    .state      (light_state),
    .green_lamp (green_lamp),
    .blue_lamp  (blue_lamp)
  );

  assign idle_lamp = b1_status.stopped && b2_status.stopped;

  assign out_data_nxt = {7'd0, b2_status.boxes_filled, blue_lamp, green_lamp,
                         b2_status.busy, b2_status.belt_run, b1_status.pusher_drive,
                         b1_status.press_drive, idle_lamp, b1_status.busy,
                         b1_status.belt_run};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/csp_belt1.sv @@
`timescale 1ns / 1ps
module csp_belt1 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  csp_pkg::scan_t        scan,
  input  csp_pkg::cfg_t         cfg,
  input  csp_pkg::b2_state_t    b2_state,
  input  csp_pkg::light_state_t light_state,
  output csp_pkg::b1_status_t   status
);

  csp_pkg::b1_state_t state_r, state_nxt;
  logic               entry_prev_r;
  logic [31:0]        press_start_r, press_start_nxt;
  logic [31:0]        elapsed;
  logic               hold_done;
  logic               entry_fall;

  // A push wins for a matching mode; a press overrides when both tests hit.
  function automatic csp_pkg::b1_state_t color_route(
    input csp_pkg::b1_state_t    cur,
    input logic [3:0]            color,
    input csp_pkg::light_state_t light,
    input logic [3:0]            blue,
    input logic [3:0]            green
  );
    csp_pkg::b1_state_t nxt;
    nxt = cur;
    if ((color == blue && light == csp_pkg::L_BLUE) ||
        (color == green && light == csp_pkg::L_GREEN)) begin
      nxt = csp_pkg::B1_PUSH;
    end
    if ((color == blue && light == csp_pkg::L_GREEN) ||
        (color == green && light == csp_pkg::L_BLUE)) begin
      nxt = csp_pkg::B1_PRESS_DOWN;
    end
    return nxt;
  endfunction

  assign entry_fall = !scan.entry_sensor && entry_prev_r;
  assign elapsed    = scan.time_now - press_start_r;
  assign hold_done  = elapsed >= {16'd0, cfg.press_hold_ms};

  always_comb begin
    state_nxt       = state_r;
    press_start_nxt = press_start_r;
    case (state_r)
      csp_pkg::B1_STOP: begin
        if (scan.start_button && !scan.entry_sensor) state_nxt = csp_pkg::B1_MOVE;
      end
      csp_pkg::B1_MOVE: begin
        if (entry_fall) begin
          state_nxt = color_route(
            (light_state == csp_pkg::L_NONE) ? csp_pkg::B1_WAIT : csp_pkg::B1_MOVE,
            scan.color_value, light_state, cfg.blue_code, cfg.green_code);
        end
      end
      csp_pkg::B1_WAIT: begin
        if (!scan.entry_sensor) begin
          state_nxt = color_route(state_r, scan.color_value, light_state,
                                  cfg.blue_code, cfg.green_code);
        end
      end
      csp_pkg::B1_PRESS_DOWN: begin
        if (!scan.press_sensor) begin
          press_start_nxt = scan.time_now;
          state_nxt       = csp_pkg::B1_PRESS_HOLD;
        end
      end
      csp_pkg::B1_PRESS_HOLD: begin
        if (hold_done) state_nxt = csp_pkg::B1_PRESS_UP;
      end
      csp_pkg::B1_PRESS_UP: begin
        if (!scan.press_sensor) begin
          state_nxt = (b2_state == csp_pkg::B2_IN) ? csp_pkg::B1_WAIT_BOX
                                                   : csp_pkg::B1_MOVE;
        end
      end
      csp_pkg::B1_PUSH: begin
        if (scan.pusher_out_sensor) state_nxt = csp_pkg::B1_RETRACT;
      end
      csp_pkg::B1_RETRACT: begin
        if (scan.pusher_in_sensor) state_nxt = csp_pkg::B1_MOVE;
      end
      csp_pkg::B1_WAIT_BOX: begin
        if (b2_state == csp_pkg::B2_COUNT) state_nxt = csp_pkg::B1_MOVE;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  always_comb begin
    status.belt_run     = (state_nxt == csp_pkg::B1_MOVE);
    status.busy         = (state_nxt != csp_pkg::B1_STOP);
    status.stopped      = (state_nxt == csp_pkg::B1_STOP);
    status.press_drive  = (state_nxt == csp_pkg::B1_PRESS_DOWN) ||
                          (state_nxt == csp_pkg::B1_PRESS_HOLD);
    status.pusher_drive = (state_nxt == csp_pkg::B1_PUSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= csp_pkg::B1_STOP;
      entry_prev_r  <= 1'b0;
      press_start_r <= 32'd0;
    end else if (step_en) begin
      state_r       <= state_nxt;
      entry_prev_r  <= scan.entry_sensor;
      press_start_r <= press_start_nxt;
    end
  end

endmodule

@@ src/csp_belt2.sv @@
`timescale 1ns / 1ps
module csp_belt2 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  csp_pkg::scan_t      scan,
  input  csp_pkg::cfg_t       cfg,
  output csp_pkg::b2_state_t  state,
  output csp_pkg::b2_status_t status
);

  csp_pkg::b2_state_t state_r, state_nxt;
  logic [3:0]         count_r, count_nxt;
  logic [3:0]         count_step;
  logic               drop_prev_r;
  logic               drop_fall;
  logic [15:0]        boxes_r, boxes_nxt;

  assign drop_fall  = !scan.drop_sensor && drop_prev_r;
  assign count_step = count_r +
                      {3'd0, (drop_fall && (count_r != csp_pkg::PIECE_MAX))};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    boxes_nxt = boxes_r;
    case (state_r)
      csp_pkg::B2_STOP: begin
        if (scan.start_button && scan.box_sensor) state_nxt = csp_pkg::B2_IN;
      end
      csp_pkg::B2_IN: begin
        if (!scan.box_sensor) begin
          count_nxt = 4'd0;
          state_nxt = csp_pkg::B2_COUNT;
        end
      end
      csp_pkg::B2_COUNT: begin
        count_nxt = count_step;
        if ((count_step >= cfg.pieces_per_box) && !scan.drop_sensor) begin
          boxes_nxt = boxes_r + 16'd1;
          state_nxt = csp_pkg::B2_OUT;
        end
      end
      csp_pkg::B2_OUT: begin
        if (scan.box_sensor) state_nxt = csp_pkg::B2_IN;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  always_comb begin
    status.belt_run     = (state_nxt == csp_pkg::B2_IN) || (state_nxt == csp_pkg::B2_OUT);
    status.busy         = (state_nxt != csp_pkg::B2_STOP);
    status.stopped      = (state_nxt == csp_pkg::B2_STOP);
    status.boxes_filled = boxes_nxt;
  end

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csp_pkg::B2_STOP;
      count_r     <= 4'd0;
      drop_prev_r <= 1'b0;
      boxes_r     <= 16'd0;
    end else if (step_en) begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_prev_r <= scan.drop_sensor;
      boxes_r     <= boxes_nxt;
    end
  end

endmodule

@@ src/csp_lights.sv @@
`timescale 1ns / 1ps
module csp_lights (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  csp_pkg::scan_t        scan,
  output csp_pkg::light_state_t state,
  output logic                  green_lamp,
  output logic                  blue_lamp
);

  csp_pkg::light_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csp_pkg::L_NONE: begin
        if (scan.blue_switch) begin
          state_nxt = csp_pkg::L_BLUE;
        end else if (scan.green_switch) begin
          state_nxt = csp_pkg::L_GREEN;
        end
      end
      csp_pkg::L_BLUE, csp_pkg::L_GREEN: begin
        if (!scan.blue_switch && !scan.green_switch) state_nxt = csp_pkg::L_NONE;
      end
      default: begin
        state_nxt = state_r;
      end
    endcase
  end

  always_comb begin
    green_lamp = (state_nxt == csp_pkg::L_GREEN);
    blue_lamp  = (state_nxt == csp_pkg::L_BLUE);
  end

  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= csp_pkg::L_NONE;
    end else if (step_en) begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/csp_checker.sv @@
`timescale 1ns / 1ps
module csp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [csp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [csp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [csp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input logic [csp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic unused_ok;
  assign unused_ok = ^{in_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

  // No result is offered right after a reset cycle.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // A result that is not taken keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // The input side only stalls while a result waits on the output side.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

  // A scan taken while the output side drains leads to a result offered from the output register.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (!out_tvalid || out_tready) |=> ##1 out_tvalid)
    else $error("scan did not produce a result");

endmodule

bind conveyor_sort_press_controller csp_checker u_csp_checker (.*);

@@ tb/conveyor_sort_press_controller_tb.sv @@
`timescale 1ns / 1ps
module conveyor_sort_press_controller_tb;

  typedef struct packed {
    logic [31:0] time_now;
    logic        green_switch;
    logic        blue_switch;
    logic        drop_sensor;
    logic        box_sensor;
    logic        pusher_in_sensor;
    logic        pusher_out_sensor;
    logic        press_sensor;
    logic [3:0]  color_value;
    logic        entry_sensor;
    logic        start_button;
  } sensor_scan_t;

  typedef struct packed {
    logic [6:0]  fill;
    logic [15:0] boxes_filled;
    logic        blue_lamp;
    logic        green_lamp;
    logic        station2_busy;
    logic        belt2_run;
    logic        pusher_drive;
    logic        press_drive;
    logic        idle_lamp;
    logic        station1_busy;
    logic        belt1_run;
  } actuation_t;

  typedef struct {
    sensor_scan_t scan;
    bit           known;
    logic [31:0]  word;
  } scan_row_t;

  typedef struct {
    logic [15:0] hold;
    logic [3:0]  pieces;
    logic [3:0]  blue;
    logic [3:0]  green;
    int          step;
  } cfg_set_t;

  localparam int DIR_ROWS    = 25;
  localparam int PHASES      = 5;
  localparam int PHASE_SCANS = 85;
  localparam int QUIET_LIMIT = 2000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [csp_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [csp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [csp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [csp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  conveyor_sort_press_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [15:0]           hold_ms;
  logic [3:0]            pieces_needed;
  logic [3:0]            blue_c;
  logic [3:0]            green_c;
  csp_pkg::b1_state_t    b1;
  csp_pkg::b2_state_t    b2;
  csp_pkg::light_state_t lit;
  logic [3:0]            piece_cnt;
  logic [31:0]           press_t0;
  logic                  drop_q;
  logic                  entry_q;
  logic [15:0]           box_cnt;

  actuation_t pending_actuation[$];
  int mismatch_total = 0;
  int scans_sent = 0;
  int results_checked = 0;
  int quiet_cycles = 0;
  int out_hold = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  logic [31:0] clock_ms = '0;
  int          time_step_max = 400;
  bit          ent_lvl = 1'b0;
  bit          drop_lvl = 1'b0;
  bit          box_lvl = 1'b0;
  bit          bsw_lvl = 1'b0;
  bit          gsw_lvl = 1'b0;

  // Columns: time, green sw, blue sw, drop, box, pusher in, pusher out, press, color, entry, start.
  scan_row_t dir_rows [DIR_ROWS] = '{
    '{'{32'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0}, 1'b1, 32'h04},
    '{'{32'd10,   1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b1}, 1'b1, 32'h63},
    '{'{32'd20,   1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{32'd30,   1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd1, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd100,  1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1599, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1600, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1610, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1620, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1630, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1640, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1650, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1660, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1670, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1680, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd4, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1690, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd4, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1700, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1710, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1720, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1730, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b1, 1'b0}, 1'b0, 32'h0},
    '{'{32'd1740, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd1, 1'b0, 1'b0}, 1'b0, 32'h0},
    '{'{32'hFFFF_FF00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0, 1'b0},
      1'b0, 32'h0},
    '{'{32'h0000_04DB, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0},
      1'b0, 32'h0},
    '{'{32'h0000_04DC, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0, 1'b0},
      1'b0, 32'h0},
    '{'{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd15, 1'b1, 1'b1},
      1'b0, 32'h0}
  };

  cfg_set_t cfg_sets [PHASES-1] = '{
    '{16'd0,     4'd1,  4'd0,  4'd15, 400},
    '{16'd65535, 4'd15, 4'd15, 4'd0,  20000},
    '{16'd300,   4'd0,  4'd7,  4'd7,  300},
    '{16'd1500,  4'd3,  4'd4,  4'd1,  600}
  };

  function automatic csp_pkg::b1_state_t route_color(csp_pkg::b1_state_t cur,
                                                     logic [3:0] color,
                                                     csp_pkg::light_state_t l);
    csp_pkg::b1_state_t nxt;
    nxt = cur;
    if ((color == blue_c && l == csp_pkg::L_BLUE) ||
        (color == green_c && l == csp_pkg::L_GREEN))
      nxt = csp_pkg::B1_PUSH;
    if ((color == blue_c && l == csp_pkg::L_GREEN) ||
        (color == green_c && l == csp_pkg::L_BLUE))
      nxt = csp_pkg::B1_PRESS_DOWN;
    return nxt;
  endfunction

  // The first belt reacts to the box belt and light states from before this scan.
  function automatic actuation_t advance_cell(sensor_scan_t s);
    actuation_t            r;
    logic                  drop_fell;
    logic                  entry_fell;
    csp_pkg::b2_state_t    prev_b2;
    csp_pkg::light_state_t prev_lit;
    csp_pkg::b1_state_t    nxt;
    drop_fell  = !s.drop_sensor && drop_q;
    entry_fell = !s.entry_sensor && entry_q;
    prev_b2    = b2;
    prev_lit   = lit;
    drop_q     = s.drop_sensor;
    entry_q    = s.entry_sensor;

    case (b1)
      csp_pkg::B1_STOP: if (s.start_button && !s.entry_sensor) b1 = csp_pkg::B1_MOVE;
      csp_pkg::B1_MOVE: begin
        if (entry_fell) begin
          nxt = (prev_lit == csp_pkg::L_NONE) ? csp_pkg::B1_WAIT : b1;
          b1 = route_color(nxt, s.color_value, prev_lit);
        end
      end
      csp_pkg::B1_WAIT: begin
        if (!s.entry_sensor) b1 = route_color(b1, s.color_value, prev_lit);
      end
      csp_pkg::B1_PRESS_DOWN: begin
        if (!s.press_sensor) begin
          press_t0 = s.time_now;
          b1 = csp_pkg::B1_PRESS_HOLD;
        end
      end
      csp_pkg::B1_PRESS_HOLD: begin
        if ((s.time_now - press_t0) >= {16'd0, hold_ms}) b1 = csp_pkg::B1_PRESS_UP;
      end
      csp_pkg::B1_PRESS_UP: begin
        if (!s.press_sensor) begin
          b1 = (prev_b2 == csp_pkg::B2_IN) ? csp_pkg::B1_WAIT_BOX : csp_pkg::B1_MOVE;
        end
      end
      csp_pkg::B1_PUSH: if (s.pusher_out_sensor) b1 = csp_pkg::B1_RETRACT;
      csp_pkg::B1_RETRACT: if (s.pusher_in_sensor) b1 = csp_pkg::B1_MOVE;
      csp_pkg::B1_WAIT_BOX: if (prev_b2 == csp_pkg::B2_COUNT) b1 = csp_pkg::B1_MOVE;
      default: ;
    endcase

    case (b2)
      csp_pkg::B2_STOP: if (s.start_button && s.box_sensor) b2 = csp_pkg::B2_IN;
      csp_pkg::B2_IN: begin
        if (!s.box_sensor) begin
          piece_cnt = '0;
          b2 = csp_pkg::B2_COUNT;
        end
      end
      csp_pkg::B2_COUNT: begin
        if (drop_fell && piece_cnt < csp_pkg::PIECE_MAX) piece_cnt = piece_cnt + 4'd1;
        if (piece_cnt >= pieces_needed && !s.drop_sensor) begin
          box_cnt = box_cnt + 16'd1;
          b2 = csp_pkg::B2_OUT;
        end
      end
      default: if (s.box_sensor) b2 = csp_pkg::B2_IN;
    endcase

    if (lit == csp_pkg::L_NONE) begin
      if (s.blue_switch) lit = csp_pkg::L_BLUE;
      else if (s.green_switch) lit = csp_pkg::L_GREEN;
    end else if (!s.blue_switch && !s.green_switch) begin
      lit = csp_pkg::L_NONE;
    end

    r = '0;
    r.belt1_run     = (b1 == csp_pkg::B1_MOVE);
    r.station1_busy = (b1 != csp_pkg::B1_STOP);
    r.idle_lamp     = (b1 == csp_pkg::B1_STOP) && (b2 == csp_pkg::B2_STOP);
    r.press_drive   = (b1 == csp_pkg::B1_PRESS_DOWN) || (b1 == csp_pkg::B1_PRESS_HOLD);
    r.pusher_drive  = (b1 == csp_pkg::B1_PUSH);
    r.belt2_run     = (b2 == csp_pkg::B2_IN) || (b2 == csp_pkg::B2_OUT);
    r.station2_busy = (b2 != csp_pkg::B2_STOP);
    r.green_lamp    = (lit == csp_pkg::L_GREEN);
    r.blue_lamp     = (lit == csp_pkg::L_BLUE);
    r.boxes_filled  = box_cnt;
    return r;
  endfunction

  // Mostly a plausible plant that answers the controller, with some scans of pure noise.
  function automatic sensor_scan_t plant_scan();
    sensor_scan_t s;
    if ($urandom_range(0, 6) == 0) begin
      s.time_now = $urandom;
      {s.green_switch, s.blue_switch, s.drop_sensor, s.box_sensor, s.pusher_in_sensor,
       s.pusher_out_sensor, s.press_sensor, s.color_value, s.entry_sensor,
       s.start_button} = 13'($urandom_range(0, 8191));
      return s;
    end
    clock_ms = clock_ms + $urandom_range(0, time_step_max);
    if ($urandom_range(0, 40) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    if ($urandom_range(0, 9) == 0) begin
      bsw_lvl = 1'($urandom_range(0, 1));
      gsw_lvl = 1'($urandom_range(0, 1));
    end
    case (b1)
      csp_pkg::B1_MOVE: if ($urandom_range(0, 2) == 0) ent_lvl = !ent_lvl;
      csp_pkg::B1_WAIT: ent_lvl = 1'($urandom_range(0, 1));
      csp_pkg::B1_STOP: ent_lvl = ($urandom_range(0, 3) == 0);
      default: if ($urandom_range(0, 9) == 0) ent_lvl = !ent_lvl;
    endcase
    case (b2)
      csp_pkg::B2_IN:    box_lvl = ($urandom_range(0, 3) != 0);
      csp_pkg::B2_COUNT: box_lvl = 1'($urandom_range(0, 1));
      default:           box_lvl = ($urandom_range(0, 4) < 2);
    endcase
    if (b2 == csp_pkg::B2_COUNT) begin
      if ($urandom_range(0, 1) == 0) drop_lvl = !drop_lvl;
    end else begin
      drop_lvl = ($urandom_range(0, 5) == 0);
    end
    case ($urandom_range(0, 5))
      0, 1:    s.color_value = blue_c;
      2, 3:    s.color_value = green_c;
      default: s.color_value = 4'($urandom_range(0, 15));
    endcase
    s.time_now          = clock_ms;
    s.start_button      = (b1 == csp_pkg::B1_STOP || b2 == csp_pkg::B2_STOP) ?
                          ($urandom_range(0, 2) != 0) : 1'($urandom_range(0, 1));
    s.press_sensor      = (b1 == csp_pkg::B1_PRESS_DOWN || b1 == csp_pkg::B1_PRESS_UP) ?
                          ($urandom_range(0, 4) >= 2) : 1'($urandom_range(0, 1));
    s.pusher_out_sensor = (b1 == csp_pkg::B1_PUSH) ? ($urandom_range(0, 4) < 2)
                                                   : ($urandom_range(0, 4) == 0);
    s.pusher_in_sensor  = (b1 == csp_pkg::B1_RETRACT) ? ($urandom_range(0, 4) < 2)
                                                      : 1'($urandom_range(0, 1));
    s.entry_sensor      = ent_lvl;
    s.box_sensor        = box_lvl;
    s.drop_sensor       = drop_lvl;
    s.blue_switch       = bsw_lvl;
    s.green_switch      = gsw_lvl;
    return s;
  endfunction

  function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0d ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic send_scan(sensor_scan_t s, bit known, logic [31:0] known_word);
    actuation_t want;
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {3'b000, s};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    want = advance_cell(s);
    if (known) want = actuation_t'(known_word);
    pending_actuation.push_back(want);
    scans_sent++;
  endtask

  task automatic write_reg(csp_pkg::cfg_idx_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      csp_pkg::CFG_PRESS_HOLD: hold_ms       = value;
      csp_pkg::CFG_PIECES:     pieces_needed = value[3:0];
      csp_pkg::CFG_BLUE_CODE:  blue_c        = value[3:0];
      default:                 green_c       = value[3:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready = (out_hold == 0);
    if (out_hold > 0) out_hold--;
  end

  always @(posedge clk) begin
    actuation_t want;
    actuation_t got;
    int errs;
    if (rst_n && out_tvalid && out_tready) begin
      got = actuation_t'(out_tdata);
      if (pending_actuation.size() == 0) begin
        $display("%0d ns: unexpected result transfer, expected none, actual 0x%0h",
                 $time, out_tdata);
        mismatch_total++;
      end else begin
        want = pending_actuation.pop_front();
        errs = field_diff("belt1_run", 16'(want.belt1_run), 16'(got.belt1_run))
             + field_diff("station1_busy", 16'(want.station1_busy), 16'(got.station1_busy))
             + field_diff("idle_lamp", 16'(want.idle_lamp), 16'(got.idle_lamp))
             + field_diff("press_drive", 16'(want.press_drive), 16'(got.press_drive))
             + field_diff("pusher_drive", 16'(want.pusher_drive), 16'(got.pusher_drive))
             + field_diff("belt2_run", 16'(want.belt2_run), 16'(got.belt2_run))
             + field_diff("station2_busy", 16'(want.station2_busy), 16'(got.station2_busy))
             + field_diff("green_lamp", 16'(want.green_lamp), 16'(got.green_lamp))
             + field_diff("blue_lamp", 16'(want.blue_lamp), 16'(got.blue_lamp))
             + field_diff("boxes_filled", want.boxes_filled, got.boxes_filled)
             + field_diff("zero fill", 16'(want.fill), 16'(got.fill));
        if (errs != 0) mismatch_total++;
      end
      results_checked++;
      out_hold = out_burst ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer.", QUIET_LIMIT);
      $display("conveyor_sort_press_controller_tb: FAIL");
      $finish;
    end
  end

  initial begin
    cfg_set_t cs;
    hold_ms       = csp_pkg::HOLD_MS_RST;
    pieces_needed = csp_pkg::PIECES_RST;
    blue_c        = csp_pkg::BLUE_CODE_RST;
    green_c       = csp_pkg::GREEN_CODE_RST;
    b1            = csp_pkg::B1_STOP;
    b2            = csp_pkg::B2_STOP;
    lit           = csp_pkg::L_NONE;
    piece_cnt     = '0;
    press_t0      = '0;
    drop_q        = 1'b0;
    entry_q       = 1'b0;
    box_cnt       = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_scan(dir_rows[i].scan, dir_rows[i].known, dir_rows[i].word);

    for (int p = 0; p < PHASES; p++) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      while (pending_actuation.size() != 0) @(posedge clk);
      repeat (4) @(negedge clk);
      if (p < PHASES - 1) begin
        cs = cfg_sets[p];
      end else begin
        cs.hold   = 16'($urandom_range(0, 800));
        cs.pieces = 4'($urandom_range(1, 15));
        cs.blue   = 4'($urandom_range(0, 15));
        cs.green  = 4'($urandom_range(0, 15));
        cs.step   = 400;
      end
      write_reg(csp_pkg::CFG_PRESS_HOLD, cs.hold);
      write_reg(csp_pkg::CFG_PIECES, {12'd0, cs.pieces});
      write_reg(csp_pkg::CFG_BLUE_CODE, {12'd0, cs.blue});
      write_reg(csp_pkg::CFG_GREEN_CODE, {12'd0, cs.green});
      time_step_max = cs.step;
      for (int i = 0; i < PHASE_SCANS; i++)
        send_scan(plant_scan(), 1'b0, 32'h0);
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_actuation.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d scans (%0d directed) under %0d register settings; %0d results checked.",
             scans_sent, DIR_ROWS, PHASES + 1, results_checked);
    $display("Final box count %0d, %0d mismatching results.", box_cnt, mismatch_total);
    if (mismatch_total == 0 && pending_actuation.size() == 0) begin
      $display("conveyor_sort_press_controller_tb: PASS");
    end else begin
      $display("conveyor_sort_press_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
